>>> src/ppae_pkg.sv
// Package for the palettised pixel decoder with packed alpha.
// Holds the command and alpha mode codes, field widths and the alpha request struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ppae_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   localparam int CMD_W    = 1;
   localparam int INDEX_W  = 8;
   localparam int COLOUR_W = 32;
   localparam int CHAN_W   = 8;
   localparam int MODE_W   = 4;
   localparam int POS_W    = 3;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PALETTE_WRITE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_PIXEL         = 1'b1;

   // Alpha mode codes; every other code means opaque.
   localparam logic [MODE_W-1:0] ALPHA_MODE_BIT    = 4'd1;
   localparam logic [MODE_W-1:0] ALPHA_MODE_NIBBLE = 4'd4;
   localparam logic [MODE_W-1:0] ALPHA_MODE_BYTE   = 4'd8;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE   = 8'hFF;
   localparam logic [CHAN_W-1:0] NIBBLE_LO_MASK = 8'h0F;
   localparam logic [CHAN_W-1:0] NIBBLE_HI_MASK = 8'hF0;

   // Request from the top level to the alpha unit for one accepted pixel word.
   typedef struct packed {
      logic              take;
      logic              first_pixel;
      logic [CHAN_W-1:0] alpha_byte;
   } alpha_req_type;

endpackage

`default_nettype wire

>>> src/ppae_if.sv
// Channel interfaces of the palettised pixel decoder: request, response, register write.
// Depends on ppae_pkg for the field widths.
`default_nettype none

interface ppae_req_if import ppae_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [INDEX_W-1:0]  palette_slot;
   logic [COLOUR_W-1:0] palette_word;
   logic [INDEX_W-1:0]  color_index;
   logic [CHAN_W-1:0]   alpha_byte;
   logic                first_pixel;

   modport source (output valid, cmd, palette_slot, palette_word, color_index,
                   alpha_byte, first_pixel, input ready);
   modport sink   (input valid, cmd, palette_slot, palette_word, color_index,
                   alpha_byte, first_pixel, output ready);
endinterface

interface ppae_rsp_if import ppae_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface ppae_csr_if import ppae_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] alpha_bits;

   modport source (output valid, alpha_bits, input ready);
   modport sink   (input valid, alpha_bits, output ready);
endinterface

`default_nettype wire

>>> src/ppae_palette_ram.sv
// Palette memory: one write port and one read port, read data registered.
// Depends on ppae_pkg for the colour word width.
`default_nettype none

module ppae_palette_ram
   import ppae_pkg::*;
#(
   parameter int DEPTH = PALETTE_ENTRIES_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [COLOUR_W-1:0] wr_data,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output      logic [COLOUR_W-1:0] rd_data
);

   logic [COLOUR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data holds until the next read, so a stalled pixel keeps its colour.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/ppae_alpha_unit.sv
// Alpha unit: keeps the pixel position and picks the alpha of each pixel.
// Depends on ppae_pkg for mode codes and the request struct.
`default_nettype none

module ppae_alpha_unit
   import ppae_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire alpha_req_type     req,
   input  wire logic [MODE_W-1:0] mode,
   output      logic [CHAN_W-1:0] alpha
);

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  pos_used;
   logic [CHAN_W-1:0] alpha_ff;
   logic [CHAN_W-1:0] alpha_in;

   assign pos_used = req.first_pixel ? '0 : pos_ff;
   assign pos_in   = req.take ? pos_used + POS_W'(1) : pos_ff;

   always_comb begin
      unique case (mode)
         ALPHA_MODE_BIT:    alpha_in = {{(CHAN_W-1){1'b0}}, req.alpha_byte[pos_used]};
         ALPHA_MODE_NIBBLE: alpha_in = pos_used[0]
                                       ? ((req.alpha_byte & NIBBLE_HI_MASK) >> 4)
                                       : (req.alpha_byte & NIBBLE_LO_MASK);
         ALPHA_MODE_BYTE:   alpha_in = req.alpha_byte;
         default:           alpha_in = ALPHA_OPAQUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.take) begin
         alpha_ff <= alpha_in;
      end
   end

   assign alpha = alpha_ff;

`ifndef SYNTHESIS
   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      (req.take && req.first_pixel) |=> (pos_ff == POS_W'(1)))
      else $error("pixel position did not restart on a first pixel");

   a_pos_steps: assert property (@(posedge clock) disable iff (reset)
      (req.take && !req.first_pixel) |=> (pos_ff == POS_W'($past(pos_ff) + POS_W'(1))))
      else $error("pixel position did not advance by one");

   a_pos_holds: assert property (@(posedge clock) disable iff (reset)
      !req.take |=> $stable(pos_ff))
      else $error("pixel position moved without a pixel word");
`endif

endmodule

`default_nettype wire

>>> src/palette_pixel_alpha_expand.sv
// Top level of the palettised pixel decoder with packed alpha.
// Depends on ppae_pkg, ppae_if, ppae_palette_ram and ppae_alpha_unit.
`default_nettype none

//  channel   dir  handshake      carries
//  req_chan  in   valid/ready    cmd, palette_slot, palette_word, color_index,
//                                alpha_byte, first_pixel
//  rsp_chan  out  valid/ready    red, green, blue, alpha (one word per pixel)
//  csr_chan  in   valid/ready    alpha_bits (alpha mode register)
//
// One request word is taken every clock cycle while req_chan is ready; a pixel word
// passes the registered palette read port and then the output register before it
// appears on rsp_chan. Palette writes give no response word.
// Reset (synchronous, active high) clears the pipeline valid flags, the pixel
// position and the alpha mode; the palette itself is undefined until written.
// A stalled response holds the output register; the read stage behind it refills, and
// only when both are full and rsp_chan is not ready does req_chan drop ready.

module palette_pixel_alpha_expand
   import ppae_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ppae_req_if.sink   req_chan,
   ppae_rsp_if.source rsp_chan,
   ppae_csr_if.sink   csr_chan
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W+1)'(PALETTE_ENTRIES);

   // Alpha mode register; the user must write it only while the block is idle, as the block does not enforce it.
   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;

   // Read stage (palette read in flight) and output register.
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_oor_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [CHAN_W-1:0]   out_red_ff;
   logic [CHAN_W-1:0]   out_green_ff;
   logic [CHAN_W-1:0]   out_blue_ff;
   logic [CHAN_W-1:0]   out_alpha_ff;

   logic                req_take;
   logic                pix_take;
   logic                pal_write;
   logic                s1_move;
   logic                idx_in_range;
   logic [COLOUR_W-1:0] rd_colour;
   logic [CHAN_W-1:0]   s1_alpha;
   alpha_req_type       alpha_req;

   // The read stage advances whenever the output register is empty or being drained.
   assign s1_move        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign pix_take       = req_take && (req_chan.cmd == CMD_PIXEL);

   // Writes to slots past the end of the palette are dropped.
   assign pal_write    = req_take && (req_chan.cmd == CMD_PALETTE_WRITE)
                         && ({1'b0, req_chan.palette_slot} < ENTRY_LIMIT);
   assign idx_in_range = ({1'b0, req_chan.color_index} < ENTRY_LIMIT);

   assign csr_chan.ready = 1'b1;
   assign mode_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.alpha_bits : mode_ff;

   assign s1_valid_in  = pix_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_chan.ready);

   // A write and a read never share an edge, so a pixel right after a palette write
   // to the same slot already sees the new colour without any forwarding.
   ppae_palette_ram #(
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_write),
      .wr_addr (req_chan.palette_slot[AW-1:0]),
      .wr_data (req_chan.palette_word),
      .rd_en   (pix_take && idx_in_range),
      .rd_addr (req_chan.color_index[AW-1:0]),
      .rd_data (rd_colour)
   );

   assign alpha_req.take        = pix_take;
   assign alpha_req.first_pixel = req_chan.first_pixel;
   assign alpha_req.alpha_byte  = req_chan.alpha_byte;

   ppae_alpha_unit u_alpha (
      .clock (clock),
      .reset (reset),
      .req   (alpha_req),
      .mode  (mode_ff),
      .alpha (s1_alpha)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take) begin
         s1_oor_ff <= !idx_in_range;
      end
   end

   // An index past the palette gives black but keeps its alpha.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_red_ff   <= s1_oor_ff ? '0 : rd_colour[7:0];
         out_green_ff <= s1_oor_ff ? '0 : rd_colour[15:8];
         out_blue_ff  <= s1_oor_ff ? '0 : rd_colour[23:16];
         out_alpha_ff <= s1_alpha;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.red   = out_red_ff;
   assign rsp_chan.green = out_green_ff;
   assign rsp_chan.blue  = out_blue_ff;
   assign rsp_chan.alpha = out_alpha_ff;

`ifndef SYNTHESIS
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && out_valid_ff && !rsp_chan.ready))
      else $error("request side stalled while the pipeline had room");

   a_pixel_enters_read_stage: assert property (@(posedge clock) disable iff (reset)
      pix_take |=> s1_valid_ff)
      else $error("accepted pixel word did not reach the read stage");

   a_write_makes_no_word: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_chan.cmd == CMD_PALETTE_WRITE) && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("palette write produced a response word");

   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(pal_write && pix_take))
      else $error("palette read and write on the same edge");
`endif

endmodule

`default_nettype wire

>>> bench/tb_palette_pixel_alpha_expand.sv
// Self-checking testbench for palette_pixel_alpha_expand: palette loads, pixel streams
// and alpha mode changes, with a scoreboard class predicting each pixel word.
// Depends on ppae_pkg, the channel interfaces in ppae_if and the block's RTL.
`timescale 1ns / 100ps

module tb_palette_pixel_alpha_expand;
   import ppae_pkg::*;

   localparam int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT;

   // Alpha mode values outside the three real modes; all of them mean opaque.
   localparam logic [MODE_W-1:0] MODE_OPAQUE_LOW  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_OPAQUE_ODD  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_OPAQUE_HIGH = 4'd15;

   // Cycles allowed after the last pixel word before the block counts as idle:
   // two pipeline stages plus some margin for a trailing palette write.
   localparam int SETTLE_CYCLES = 4;
   // Random words per alpha mode phase; ten phases give about 1050 in total.
   localparam int PHASE_WORDS   = 105;
   localparam int PHASE_COUNT   = 10;
   // Watchdog. The slowest correct run pays a long sender gap and a long stall on
   // every word, and this limit is several times that.
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [INDEX_W-1:0]  palette_slot;
      logic [COLOUR_W-1:0] palette_word;
      logic [INDEX_W-1:0]  color_index;
      logic [CHAN_W-1:0]   alpha_byte;
      logic                first_pixel;
   } request_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_word_type;

   // The scoreboard keeps its own palette, pixel position and alpha mode, turns every
   // accepted pixel word into the colour word the block ought to return, and checks
   // the returned words in order against that queue.
   class pixel_scoreboard;
      logic [COLOUR_W-1:0] palette [PALETTE_ENTRIES];
      logic [POS_W-1:0]    position;
      logic [MODE_W-1:0]   alpha_mode;
      pixel_word_type      pending [$];
      int unsigned         failures;
      int unsigned         pixels_seen;
      int unsigned         writes_seen;
      int unsigned         pixels_checked;

      function new();
         position       = '0;
         alpha_mode     = '0;
         failures       = 0;
         pixels_seen    = 0;
         writes_seen    = 0;
         pixels_checked = 0;
      endfunction

      function logic [CHAN_W-1:0] unpack_alpha(logic [CHAN_W-1:0] src,
                                               logic [POS_W-1:0] pos);
         case (alpha_mode)
            ALPHA_MODE_BIT:    return {{(CHAN_W-1){1'b0}}, src[pos]};
            ALPHA_MODE_NIBBLE: return pos[0] ? (src & NIBBLE_HI_MASK) >> 4
                                             : (src & NIBBLE_LO_MASK);
            ALPHA_MODE_BYTE:   return src;
            default:           return ALPHA_OPAQUE;
         endcase
      endfunction

      function void note_request(request_word_type w);
         logic [POS_W-1:0]    used;
         logic [COLOUR_W-1:0] colour;
         pixel_word_type      px;
         if (w.cmd == CMD_PALETTE_WRITE) begin
            writes_seen++;
            if (w.palette_slot < PALETTE_ENTRIES)
               palette[w.palette_slot] = w.palette_word;
            return;
         end
         pixels_seen++;
         used     = w.first_pixel ? '0 : position;
         colour   = (w.color_index < PALETTE_ENTRIES) ? palette[w.color_index] : '0;
         px.red   = colour[7:0];
         px.green = colour[15:8];
         px.blue  = colour[23:16];
         px.alpha = unpack_alpha(w.alpha_byte, used);
         pending.push_back(px);
         position = used + 1'b1;
      endfunction

      function void report(string what, pixel_word_type want, pixel_word_type got);
         failures++;
         if (failures <= 10)
            $display("%0t: %0s: expected r=%02h g=%02h b=%02h a=%02h, got r=%02h g=%02h b=%02h a=%02h",
                     $time, what, want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
      endfunction

      function void check_response(pixel_word_type got);
         pixel_word_type want;
         if (pending.size() == 0) begin
            report("pixel word with nothing outstanding", '0, got);
            return;
         end
         want = pending.pop_front();
         pixels_checked++;
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha)
            report("pixel word mismatch", want, got);
      endfunction
   endclass

   logic clock;
   logic reset;

   ppae_req_if req_chan ();
   ppae_rsp_if rsp_chan ();
   ppae_csr_if csr_chan ();

   palette_pixel_alpha_expand dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pixel_scoreboard sb;

   // Idling switches, changed per sequence so that both quiet and ragged stretches occur.
   bit          source_idles;
   bit          sink_stalls;
   int unsigned words_sent;
   int unsigned modes_used;
   int unsigned cycle_count;

   // Slots that hold a colour; pixels only ever index these.
   bit          slot_loaded [PALETTE_ENTRIES];
   int unsigned loaded_slots [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Receiver: ready is held high for a random run, then dropped for a random gap
   // whenever stalls are switched on.
   initial begin
      int unsigned n;
      rsp_chan.ready <= 1'b1;
      forever begin
         n = sink_stalls ? gap_length() : 0;
         if (n != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Observes every handshake on the pre-edge values and feeds the scoreboard.
   always @(posedge clock) begin : observe
      request_word_type taken;
      pixel_word_type   shown;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready)
            sb.alpha_mode = csr_chan.alpha_bits;
         if (req_chan.valid && req_chan.ready) begin
            taken.cmd          = req_chan.cmd;
            taken.palette_slot = req_chan.palette_slot;
            taken.palette_word = req_chan.palette_word;
            taken.color_index  = req_chan.color_index;
            taken.alpha_byte   = req_chan.alpha_byte;
            taken.first_pixel  = req_chan.first_pixel;
            sb.note_request(taken);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            shown.red   = rsp_chan.red;
            shown.green = rsp_chan.green;
            shown.blue  = rsp_chan.blue;
            shown.alpha = rsp_chan.alpha;
            sb.check_response(shown);
         end
      end
   end

   task automatic sender_gap();
      int unsigned n;
      n = gap_length();
      if (n != 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Presents one request word and returns at the edge where it is taken. Valid stays
   // high into the next call unless a gap lowers it.
   task automatic send_request(input request_word_type w);
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= w.cmd;
      req_chan.palette_slot <= w.palette_slot;
      req_chan.palette_word <= w.palette_word;
      req_chan.color_index  <= w.color_index;
      req_chan.alpha_byte   <= w.alpha_byte;
      req_chan.first_pixel  <= w.first_pixel;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      if (source_idles)
         sender_gap();
   endtask

   // The fields a word does not use carry random junk, which the block must ignore.
   task automatic write_palette(input logic [INDEX_W-1:0] slot,
                                input logic [COLOUR_W-1:0] colour);
      request_word_type w;
      w.cmd          = CMD_PALETTE_WRITE;
      w.palette_slot = slot;
      w.palette_word = colour;
      w.color_index  = INDEX_W'($urandom);
      w.alpha_byte   = CHAN_W'($urandom);
      w.first_pixel  = 1'($urandom);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.push_back(32'(slot));
      end
      send_request(w);
   endtask

   task automatic send_pixel(input logic [INDEX_W-1:0] index,
                             input logic [CHAN_W-1:0] abyte, input logic first);
      request_word_type w;
      w.cmd          = CMD_PIXEL;
      w.palette_slot = INDEX_W'($urandom);
      w.palette_word = $urandom;
      w.color_index  = index;
      w.alpha_byte   = abyte;
      w.first_pixel  = first;
      send_request(w);
   endtask

   // Holds the sender off until every pixel word has come back, then lets the
   // pipeline empty behind any trailing palette write. The first edge lets the
   // observer log a word taken at the edge this task was entered on.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The mode register is only ever written with the block idle.
   task automatic set_alpha_mode(input logic [MODE_W-1:0] mode);
      drain();
      csr_chan.valid      <= 1'b1;
      csr_chan.alpha_bits <= mode;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      modes_used++;
   endtask

   function automatic logic [INDEX_W-1:0] pick_loaded_slot();
      return INDEX_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
   endfunction

   function automatic logic [COLOUR_W-1:0] random_colour();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic choose_idling();
      int unsigned r;
      r = $urandom_range(0, 3);
      source_idles = r[0];
      sink_stalls  = r[1];
   endtask

   // One image: a first pixel that restarts the position, then a run of pixels with
   // the odd palette update mixed in. Long runs wrap the position past seven.
   task automatic send_image();
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 10);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0)
            write_palette(INDEX_W'($urandom_range(0, PALETTE_ENTRIES - 1)), random_colour());
         send_pixel(pick_loaded_slot(), CHAN_W'($urandom_range(0, 255)), i == 0);
      end
   endtask

   // Unstructured words: restarts at random places, loads and pixels in any order.
   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 1))
            write_palette(INDEX_W'($urandom_range(0, PALETTE_ENTRIES - 1)), random_colour());
         else
            send_pixel(pick_loaded_slot(), CHAN_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_phase(input logic [MODE_W-1:0] mode);
      int unsigned goal;
      int unsigned r;
      set_alpha_mode(mode);
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
         choose_idling();
         r = $urandom_range(0, 99);
         if (r < 15) begin
            repeat ($urandom_range(1, 6))
               write_palette(INDEX_W'($urandom_range(0, PALETTE_ENTRIES - 1)),
                             random_colour());
         end else if (r < 82) begin
            send_image();
         end else if (r < 97) begin
            send_noise();
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      logic [MODE_W-1:0] phase_modes [PHASE_COUNT];
      sb = new();
      source_idles = 1'b0;
      sink_stalls  = 1'b0;
      words_sent   = 0;
      modes_used   = 0;

      // Every input is known from time zero, while reset is held high.
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.cmd          <= CMD_PALETTE_WRITE;
      req_chan.palette_slot <= '0;
      req_chan.palette_word <= '0;
      req_chan.color_index  <= '0;
      req_chan.alpha_byte   <= '0;
      req_chan.first_pixel  <= 1'b0;
      csr_chan.valid        <= 1'b0;
      csr_chan.alpha_bits   <= MODE_OPAQUE_LOW;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Single bit mode first: the extreme slots and colours, every bit
      // of one alpha byte in turn, the wrap from position seven back to zero, and a
      // restart in the middle of a row.
      set_alpha_mode(ALPHA_MODE_BIT);
      write_palette(8'd0, 32'h0000_0000);
      write_palette(8'd255, 32'hFFFF_FFFF);
      write_palette(8'h96, 32'h80C3_5A01);
      send_pixel(8'd255, 8'hA5, 1'b1);
      for (int i = 1; i < 9; i++)
         send_pixel((i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'h96 : 8'd255, 8'hA5, 1'b0);
      send_pixel(8'h96, 8'h01, 1'b1);

      // Nibble mode: low nibble at even positions, high nibble at odd ones.
      set_alpha_mode(ALPHA_MODE_NIBBLE);
      send_pixel(8'h96, 8'h3C, 1'b1);
      send_pixel(8'h96, 8'h3C, 1'b0);
      // A rewritten entry must be read back with its new colour.
      write_palette(8'd0, 32'h00FF_00FF);
      send_pixel(8'd0, 8'hF0, 1'b0);

      // Whole byte mode at both extremes of the alpha byte.
      set_alpha_mode(ALPHA_MODE_BYTE);
      send_pixel(8'd255, 8'h00, 1'b1);
      send_pixel(8'd0, 8'hFF, 1'b0);

      // Modes outside one, four and eight all give opaque alpha.
      set_alpha_mode(MODE_OPAQUE_LOW);
      send_pixel(8'h96, 8'h00, 1'b1);
      set_alpha_mode(MODE_OPAQUE_HIGH);
      send_pixel(8'd255, 8'h5A, 1'b0);

      // Random part, one phase per alpha mode setting, with a drain before each change.
      phase_modes = '{ALPHA_MODE_BYTE, ALPHA_MODE_BIT, ALPHA_MODE_NIBBLE, MODE_OPAQUE_LOW,
                      MODE_OPAQUE_HIGH, ALPHA_MODE_NIBBLE, ALPHA_MODE_BIT, MODE_OPAQUE_ODD,
                      ALPHA_MODE_BYTE, ALPHA_MODE_BIT};
      phase_modes[PHASE_COUNT - 1] = MODE_W'($urandom_range(0, 15));
      for (int p = 0; p < PHASE_COUNT; p++)
         random_phase(phase_modes[p]);

      drain();
      repeat (8) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $display("%0d pixel words never came back", sb.pending.size());
         sb.failures += sb.pending.size();
      end

      $display("run covered %0d request words: %0d palette writes and %0d pixels",
               words_sent, sb.writes_seen, sb.pixels_seen);
      $display("%0d pixel words checked across %0d alpha mode settings, %0d slots loaded",
               sb.pixels_checked, modes_used, loaded_slots.size());
      if (sb.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
